### src/qmj_pkg.sv
// shared types, constants and saturating helpers of the quintic trajectory block
`default_nettype none
package qmj_pkg;

    // data formats
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TAU_BITS   = 32;
    localparam int ACC_W      = 64;
    localparam int TIME_W     = 31;
    localparam int DUR_W      = 31;
    localparam int SH_W       = 6;

    // register file
    localparam int NREG  = 7;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_START_POS = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_START_VEL = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_START_ACC = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_END_POS   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_END_VEL   = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_END_ACC   = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_DURATION  = IDX_W'(6);
    localparam logic [DUR_W-1:0] DUR_RESET     = DUR_W'(65536);

    // pipeline shape
    localparam int MUL_LAT    = 5;
    localparam int QUO_W      = TIME_W + TAU_BITS;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;
    localparam int EVAL_STEPS = 5;
    localparam int CNT_W      = 3;

    // saturation bounds
    localparam logic signed [ACC_W-1:0] SMAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = {1'b1, {(ACC_W-1){1'b0}}};

    // closed-form weights of the coefficient solve
    localparam logic signed [ACC_W-1:0] K_P10 = ACC_W'(10);
    localparam logic signed [ACC_W-1:0] K_M4  = -ACC_W'(4);
    localparam logic signed [ACC_W-1:0] K_M15 = -ACC_W'(15);
    localparam logic signed [ACC_W-1:0] K_P7  = ACC_W'(7);
    localparam logic signed [ACC_W-1:0] K_P6  = ACC_W'(6);
    localparam logic signed [ACC_W-1:0] K_M3  = -ACC_W'(3);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] s0;
        logic signed [DATA_WIDTH-1:0] v0;
        logic signed [DATA_WIDTH-1:0] a0;
        logic signed [DATA_WIDTH-1:0] s1;
        logic signed [DATA_WIDTH-1:0] v1;
        logic signed [DATA_WIDTH-1:0] a1;
        logic [DUR_W-1:0]             dur;
    } t_cfg;

    typedef struct packed {
        logic                    valid;
        logic                    clip;
        logic signed [ACC_W-1:0] c3;
        logic signed [ACC_W-1:0] c4;
        logic signed [ACC_W-1:0] c5;
    } t_coef;

    // per-sample context that rides along the evaluation pipeline
    typedef struct packed {
        logic [TIME_W-1:0]       ts;
        logic signed [ACC_W-1:0] tau;
        logic signed [ACC_W-1:0] pw;
        logic signed [ACC_W-1:0] ph;
        logic signed [ACC_W-1:0] acc;
        logic                    clip;
    } t_ctx;

    typedef struct packed {
        logic signed [ACC_W-1:0] v;
        logic                    c;
    } t_sres;

    // saturating add
    function automatic t_sres sadd(input logic signed [ACC_W-1:0] a,
                                   input logic signed [ACC_W-1:0] b);
        t_sres                   r;
        logic signed [ACC_W-1:0] s;
        s   = a + b;
        r.v = s;
        r.c = 1'b0;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
            r.c = 1'b1;
            r.v = a[ACC_W-1] ? SMIN : SMAX;
        end
        return r;
    endfunction

    // saturating negate
    function automatic t_sres negsat(input logic signed [ACC_W-1:0] x);
        t_sres r;
        r.v = -x;
        r.c = 1'b0;
        if (x == SMIN) begin
            r.v = SMAX;
            r.c = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sext32(input logic signed [DATA_WIDTH-1:0] x);
        return {{(ACC_W-DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
    endfunction

    // zero duration counts as one lsb
    function automatic logic [DUR_W-1:0] dur_eff(input logic [DUR_W-1:0] d);
        return (d == '0) ? DUR_W'(1) : d;
    endfunction

endpackage
`default_nettype wire

### src/qmj_mul.sv
// five-stage signed 64x64 multiplier with floor shift and 64-bit saturation
`default_nettype none
module qmj_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [qmj_pkg::ACC_W-1:0] i_a,
    input  logic signed [qmj_pkg::ACC_W-1:0] i_b,
    input  logic [qmj_pkg::SH_W-1:0]         i_sh,
    input  qmj_pkg::t_ctx                    i_ctx,
    output logic                             o_valid,
    output logic signed [qmj_pkg::ACC_W-1:0] o_p,
    output logic                             o_clip,
    output qmj_pkg::t_ctx                    o_ctx
);
    import qmj_pkg::*;

    logic [MUL_LAT-1:0]   r_vld;
    t_ctx                 r_ctx [MUL_LAT];

    logic                 r1_neg;
    logic [ACC_W-1:0]     r1_ua;
    logic [ACC_W-1:0]     r1_ub;
    logic [SH_W-1:0]      r1_sh;

    logic                 r2_neg;
    logic [SH_W-1:0]      r2_sh;
    logic [ACC_W-1:0]     r2_p00, r2_p01, r2_p10, r2_p11;
    logic [ACC_W-1:0]     w_p00, w_p01, w_p10, w_p11;

    logic                 r3_neg;
    logic [SH_W-1:0]      r3_sh;
    logic [2*ACC_W-1:0]   r3_prod;
    logic [2*ACC_W-1:0]   w_prod;

    logic                 r4_neg;
    logic [2*ACC_W-1:0]   r4_q;
    logic                 r4_rem;
    logic [2*ACC_W-1:0]   w_mask;

    logic [2*ACC_W-1:0]   w_qr;
    logic signed [ACC_W-1:0] n_p;
    logic                 n_clip;
    logic signed [ACC_W-1:0] r_p;
    logic                 r_clip;

    // valid bits and context delay line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[MUL_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= i_ctx;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_ctx[i] <= r_ctx[i-1];
            end
        end
    end

    // partial products of the magnitudes
    assign w_p00 = r1_ua[31:0]  * r1_ub[31:0];
    assign w_p01 = r1_ua[31:0]  * r1_ub[63:32];
    assign w_p10 = r1_ua[63:32] * r1_ub[31:0];
    assign w_p11 = r1_ua[63:32] * r1_ub[63:32];

    assign w_prod = {64'd0, r2_p00} + {32'd0, r2_p01, 32'd0}
                  + {32'd0, r2_p10, 32'd0} + {r2_p11, 64'd0};

    assign w_mask = ({{(2*ACC_W-1){1'b0}}, 1'b1} << r3_sh) - 1'b1;

    // round toward minus infinity and saturate
    always_comb begin
        w_qr   = r4_q + {{(2*ACC_W-1){1'b0}}, (r4_neg & r4_rem)};
        n_p    = w_qr[ACC_W-1:0];
        n_clip = 1'b0;
        if (!r4_neg) begin
            if (|w_qr[2*ACC_W-1:ACC_W-1]) begin
                n_p    = SMAX;
                n_clip = 1'b1;
            end
        end else begin
            if ((|w_qr[2*ACC_W-1:ACC_W]) || (w_qr[ACC_W-1] && (|w_qr[ACC_W-2:0]))) begin
                n_p    = SMIN;
                n_clip = 1'b1;
            end else begin
                n_p = -w_qr[ACC_W-1:0];
            end
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg  <= i_a[ACC_W-1] ^ i_b[ACC_W-1];
            r1_ua   <= i_a[ACC_W-1] ? (ACC_W'(0) - i_a) : i_a;
            r1_ub   <= i_b[ACC_W-1] ? (ACC_W'(0) - i_b) : i_b;
            r1_sh   <= i_sh;
            r2_neg  <= r1_neg;
            r2_sh   <= r1_sh;
            r2_p00  <= w_p00;
            r2_p01  <= w_p01;
            r2_p10  <= w_p10;
            r2_p11  <= w_p11;
            r3_neg  <= r2_neg;
            r3_sh   <= r2_sh;
            r3_prod <= w_prod;
            r4_neg  <= r3_neg;
            r4_q    <= r3_prod >> r3_sh;
            r4_rem  <= |(r3_prod & w_mask);
            r_p     <= n_p;
            r_clip  <= n_clip;
        end
    end

    assign o_valid = r_vld[MUL_LAT-1];
    assign o_ctx   = r_ctx[MUL_LAT-1];
    assign o_p     = r_p;
    assign o_clip  = r_clip;

endmodule
`default_nettype wire

### src/qmj_div.sv
// pipelined restoring divider that forms tau = (t << 32) / T, three bits a stage
`default_nettype none
module qmj_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [qmj_pkg::TIME_W-1:0]       i_time,
    input  logic [qmj_pkg::DUR_W-1:0]        i_dur,
    output logic                             o_valid,
    output logic [qmj_pkg::TIME_W-1:0]       o_time,
    output logic signed [qmj_pkg::ACC_W-1:0] o_tau
);
    import qmj_pkg::*;

    logic [DIV_STAGES-1:0] r_vld;
    logic [DUR_W-1:0]      r_rem  [DIV_STAGES];
    logic [QUO_W-1:0]      r_quo  [DIV_STAGES];
    logic [TIME_W-1:0]     r_time [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [DUR_W-1:0]  w_rem [DIV_STEP+1];
        logic [QUO_W-1:0]  w_quo [DIV_STEP+1];
        logic [TIME_W-1:0] w_time;
        logic              w_vin;

        if (s == 0) begin : g_first
            assign w_rem[0] = '0;
            assign w_quo[0] = '0;
            assign w_time   = i_time;
            assign w_vin    = i_valid;
        end else begin : g_next
            assign w_rem[0] = r_rem[s-1];
            assign w_quo[0] = r_quo[s-1];
            assign w_time   = r_time[s-1];
            assign w_vin    = r_vld[s-1];
        end

        // one quotient bit per step
        for (genvar i = 0; i < DIV_STEP; i++) begin : g_bit
            localparam int J = QUO_W - 1 - (s * DIV_STEP + i);
            if (J >= 0) begin : g_live
                logic             w_d;
                logic [DUR_W:0]   w_trial;
                logic [DUR_W:0]   w_diff;
                logic             w_ge;
                if (J >= TAU_BITS) begin : g_tbit
                    assign w_d = w_time[J-TAU_BITS];
                end else begin : g_zbit
                    assign w_d = 1'b0;
                end
                assign w_trial      = {w_rem[i], w_d};
                assign w_ge         = (w_trial >= {1'b0, i_dur});
                assign w_diff       = w_trial - {1'b0, i_dur};
                assign w_rem[i+1]   = w_ge ? w_diff[DUR_W-1:0] : w_trial[DUR_W-1:0];
                assign w_quo[i+1]   = {w_quo[i][QUO_W-2:0], w_ge};
            end else begin : g_pad
                assign w_rem[i+1] = w_rem[i];
                assign w_quo[i+1] = w_quo[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_rem[DIV_STEP];
                r_quo[s]  <= w_quo[DIV_STEP];
                r_time[s] <= w_time;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vin;
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_time  = r_time[DIV_STAGES-1];
    assign o_tau   = ACC_W'(r_quo[DIV_STAGES-1]);

endmodule
`default_nettype wire

### src/qmj_solve.sv
// coefficient solver: sequences the closed-form solve through one shared multiplier
`default_nettype none
module qmj_solve (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_restart,
    input  qmj_pkg::t_cfg  i_cfg,
    output qmj_pkg::t_coef o_coef
);
    import qmj_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_WAIT  = 3'b100
    } t_state;

    typedef enum logic [3:0] {
        OP_T2, OP_V0T, OP_A0T2, OP_A0T, OP_TB1, OP_T2B2, OP_H,
        OP_C3A, OP_C3B, OP_C4A, OP_C4B, OP_C5A, OP_C5B
    } t_op;

    t_state             r_state;
    t_op                r_op;
    logic [CNT_W-1:0]   r_cnt;

    logic signed [ACC_W-1:0] r_t2, r_acc, r_b0, r_b1, r_tb1, r_t2b2, r_h;
    logic signed [ACC_W-1:0] r_c3, r_c4, r_c5;
    logic                    r_clip;
    logic signed [ACC_W-1:0] n_t2, n_acc, n_b0, n_b1, n_tb1, n_t2b2, n_h;
    logic signed [ACC_W-1:0] n_c3, n_c4, n_c5;
    logic                    n_clip;

    logic signed [ACC_W-1:0] w_a, w_b, w_dur, w_b2, w_p;
    logic [SH_W-1:0]         w_sh;
    logic                    w_mvld, w_pc, w_cap;
    t_sres                   w_s1, w_s2, w_g1, w_g2;

    assign w_dur = ACC_W'(dur_eff(i_cfg.dur));
    assign w_b2  = sext32(i_cfg.a1) - sext32(i_cfg.a0);

    // operand selection per step
    always_comb begin
        w_a  = w_dur;
        w_b  = w_dur;
        w_sh = SH_W'(FRAC_BITS);
        case (r_op)
            OP_T2:   begin w_a = w_dur;             w_b = w_dur; end
            OP_V0T:  begin w_a = sext32(i_cfg.v0);  w_b = w_dur; end
            OP_A0T2: begin
                w_a  = sext32(i_cfg.a0);
                w_b  = r_t2;
                w_sh = SH_W'(FRAC_BITS + 1);
            end
            OP_A0T:  begin w_a = sext32(i_cfg.a0);  w_b = w_dur; end
            OP_TB1:  begin w_a = w_dur;             w_b = r_b1;  end
            OP_T2B2: begin w_a = r_t2;              w_b = w_b2;  end
            OP_H:    begin
                w_a  = r_t2;
                w_b  = w_b2;
                w_sh = SH_W'(FRAC_BITS + 1);
            end
            OP_C3A:  begin w_a = r_b0;  w_b = K_P10; w_sh = '0; end
            OP_C3B:  begin w_a = r_tb1; w_b = K_M4;  w_sh = '0; end
            OP_C4A:  begin w_a = r_b0;  w_b = K_M15; w_sh = '0; end
            OP_C4B:  begin w_a = r_tb1; w_b = K_P7;  w_sh = '0; end
            OP_C5A:  begin w_a = r_b0;  w_b = K_P6;  w_sh = '0; end
            OP_C5B:  begin w_a = r_tb1; w_b = K_M3;  w_sh = '0; end
            default: ;
        endcase
    end

    qmj_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (1'b1),
        .i_valid (r_state == ST_ISSUE),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_sh    (w_sh),
        .i_ctx   ('0),
        .o_valid (w_mvld),
        .o_p     (w_p),
        .o_clip  (w_pc),
        .o_ctx   ()
    );

    assign w_cap = (r_state == ST_WAIT) && (r_cnt == '0) && w_mvld;

    // fold each product into the running terms
    always_comb begin
        n_t2   = r_t2;
        n_acc  = r_acc;
        n_b0   = r_b0;
        n_b1   = r_b1;
        n_tb1  = r_tb1;
        n_t2b2 = r_t2b2;
        n_h    = r_h;
        n_c3   = r_c3;
        n_c4   = r_c4;
        n_c5   = r_c5;
        w_s1   = '0;
        w_s2   = '0;
        w_g1   = '0;
        w_g2   = '0;
        case (r_op)
            OP_T2:   n_t2 = w_p;
            OP_V0T:  begin
                w_s1  = sadd(sext32(i_cfg.s0), w_p);
                n_acc = w_s1.v;
            end
            OP_A0T2: begin
                w_s1 = sadd(r_acc, w_p);
                w_g1 = negsat(w_s1.v);
                w_s2 = sadd(sext32(i_cfg.s1), w_g1.v);
                n_b0 = w_s2.v;
            end
            OP_A0T:  begin
                w_s1 = sadd(sext32(i_cfg.v0), w_p);
                w_g2 = negsat(w_s1.v);
                w_s2 = sadd(sext32(i_cfg.v1), w_g2.v);
                n_b1 = w_s2.v;
            end
            OP_TB1:  n_tb1  = w_p;
            OP_T2B2: n_t2b2 = w_p;
            OP_H:    n_h    = w_p;
            OP_C3A:  n_c3   = w_p;
            OP_C3B:  begin
                w_s1 = sadd(r_c3, w_p);
                w_s2 = sadd(w_s1.v, r_h);
                n_c3 = w_s2.v;
            end
            OP_C4A:  n_c4 = w_p;
            OP_C4B:  begin
                w_s1 = sadd(r_c4, w_p);
                w_g2 = negsat(r_t2b2);
                w_s2 = sadd(w_s1.v, w_g2.v);
                n_c4 = w_s2.v;
            end
            OP_C5A:  n_c5 = w_p;
            OP_C5B:  begin
                w_s1 = sadd(r_c5, w_p);
                w_s2 = sadd(w_s1.v, r_h);
                n_c5 = w_s2.v;
            end
            default: ;
        endcase
        n_clip = ((r_op == OP_T2) ? 1'b0 : r_clip) | w_pc | w_s1.c | w_s2.c | w_g2.c;
    end

    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_t2   <= n_t2;
            r_acc  <= n_acc;
            r_b0   <= n_b0;
            r_b1   <= n_b1;
            r_tb1  <= n_tb1;
            r_t2b2 <= n_t2b2;
            r_h    <= n_h;
            r_c3   <= n_c3;
            r_c4   <= n_c4;
            r_c5   <= n_c5;
            r_clip <= n_clip;
        end
    end

    // sequencer: restarts on every register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= ST_ISSUE;
            r_op    <= OP_T2;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                    r_cnt   <= CNT_W'(MUL_LAT - 1);
                end
                ST_WAIT: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                    end else if (w_cap) begin
                        if (r_op == OP_C5B) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_op    <= t_op'(r_op + 4'd1);
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_IDLE: ;
                default: r_state <= ST_ISSUE;
            endcase
        end
    end

    assign o_coef.valid = (r_state == ST_IDLE);
    assign o_coef.clip  = r_clip;
    assign o_coef.c3    = r_c3;
    assign o_coef.c4    = r_c4;
    assign o_coef.c5    = r_c5;

`ifndef NO_ASSERTIONS
    // the product is due exactly when the wait count runs out
    a_result_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT && r_cnt == '0) |-> w_mvld)
        else $error("solver product not valid when due");

    // a register write drops the cache and starts over
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_restart |=> (!o_coef.valid && r_op == OP_T2))
        else $error("solver did not restart");

    // the cache only becomes valid after the last step
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_coef.valid) |-> ($past(r_op) == OP_C5B))
        else $error("coefficients valid before the solve finished");
`endif

endmodule
`default_nettype wire

### src/quintic_min_jerk_trajectory.sv
// pipeline: 47 register stages from the sample input to o_valid
// throughput: one sample per cycle while o_ready is high; the whole pipeline holds while the output is stalled
// reset (and every register write) restarts the coefficient solve, 13 multiply steps
// on one shared multiplier, with o_ready low until it ends
// registers reset to zero, duration to 1.0 s
`default_nettype none
module quintic_min_jerk_trajectory (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [qmj_pkg::IDX_W-1:0]             i_cfg_index,
    input  logic [qmj_pkg::DATA_WIDTH-1:0]        i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [qmj_pkg::TIME_W-1:0]            i_sample_time,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [qmj_pkg::DATA_WIDTH-1:0] o_position,
    output logic                                  o_saturated
);
    import qmj_pkg::*;

    t_cfg  r_cfg;
    t_coef w_coef;
    logic  w_cfg_hit;
    logic  w_en;

    logic                    w_dvld;
    logic [TIME_W-1:0]       w_dtime;
    logic signed [ACC_W-1:0] w_dtau;

    t_ctx  w_ctx [EVAL_STEPS+1];
    logic  w_vld [EVAL_STEPS+1];

    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_position;
    logic                         r_saturated;
    logic signed [DATA_WIDTH-1:0] n_position;
    logic                         n_saturated;

    // configuration registers
    assign w_cfg_hit = i_cfg_we && (i_cfg_index < IDX_W'(NREG));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_cfg.dur <= DUR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_POS: r_cfg.s0  <= i_cfg_data;
                REG_START_VEL: r_cfg.v0  <= i_cfg_data;
                REG_START_ACC: r_cfg.a0  <= i_cfg_data;
                REG_END_POS:   r_cfg.s1  <= i_cfg_data;
                REG_END_VEL:   r_cfg.v1  <= i_cfg_data;
                REG_END_ACC:   r_cfg.a1  <= i_cfg_data;
                REG_DURATION:  r_cfg.dur <= i_cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    qmj_solve u_solve (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_cfg_hit),
        .i_cfg     (r_cfg),
        .o_coef    (w_coef)
    );

    // whole pipeline advances unless the result register is held
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en && w_coef.valid && !i_cfg_we;

    qmj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid && o_ready),
        .i_time  (i_sample_time),
        .i_dur   (dur_eff(r_cfg.dur)),
        .o_valid (w_dvld),
        .o_time  (w_dtime),
        .o_tau   (w_dtau)
    );

    always_comb begin
        w_ctx[0].ts   = w_dtime;
        w_ctx[0].tau  = w_dtau;
        w_ctx[0].pw   = w_dtau;
        w_ctx[0].ph   = '0;
        w_ctx[0].acc  = sext32(r_cfg.s0);
        w_ctx[0].clip = w_coef.clip;
        w_vld[0]      = w_dvld;
    end

    // evaluation: powers of tau in unit a, weighted terms in unit b; b also squares t, a also weights c4
    for (genvar k = 0; k < EVAL_STEPS; k++) begin : g_step
        logic signed [ACC_W-1:0] w_aa, w_ab, w_ba, w_bb, w_ra, w_rb, w_ts;
        logic [SH_W-1:0]         w_ash, w_bsh;
        logic                    w_ca, w_cb, w_va;
        t_ctx                    w_dc, w_nc;
        t_sres                   w_s1, w_s2;

        assign w_ts = ACC_W'(w_ctx[k].ts);

        always_comb begin
            w_aa  = w_ctx[k].pw;
            w_ab  = w_ctx[k].tau;
            w_ash = SH_W'(TAU_BITS);
            w_ba  = '0;
            w_bb  = '0;
            w_bsh = '0;
            case (k)
                0: begin
                    w_ba  = w_ts;
                    w_bb  = w_ts;
                    w_bsh = SH_W'(FRAC_BITS);
                end
                1: begin
                    w_ba  = sext32(r_cfg.v0);
                    w_bb  = w_ts;
                    w_bsh = SH_W'(FRAC_BITS);
                end
                2: begin
                    w_ba  = sext32(r_cfg.a0);
                    w_bb  = w_ctx[k].ph;
                    w_bsh = SH_W'(FRAC_BITS + 1);
                end
                3: begin
                    w_ba  = w_coef.c3;
                    w_bb  = w_ctx[k].ph;
                    w_bsh = SH_W'(TAU_BITS);
                end
                4: begin
                    w_aa  = w_coef.c4;
                    w_ab  = w_ctx[k].ph;
                    w_ba  = w_coef.c5;
                    w_bb  = w_ctx[k].pw;
                    w_bsh = SH_W'(TAU_BITS);
                end
                default: ;
            endcase
        end

        qmj_mul u_mul_a (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[k]),
            .i_a     (w_aa),
            .i_b     (w_ab),
            .i_sh    (w_ash),
            .i_ctx   (w_ctx[k]),
            .o_valid (w_va),
            .o_p     (w_ra),
            .o_clip  (w_ca),
            .o_ctx   (w_dc)
        );

        qmj_mul u_mul_b (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[k]),
            .i_a     (w_ba),
            .i_b     (w_bb),
            .i_sh    (w_bsh),
            .i_ctx   (w_ctx[k]),
            .o_valid (),
            .o_p     (w_rb),
            .o_clip  (w_cb),
            .o_ctx   ()
        );

        // merge products into the context
        always_comb begin
            w_nc = w_dc;
            w_s1 = '0;
            w_s2 = '0;
            case (k)
                0: begin
                    w_nc.pw = w_ra;
                    w_nc.ph = w_rb;
                end
                1: begin
                    w_nc.pw  = w_ra;
                    w_s1     = sadd(w_dc.acc, w_rb);
                    w_nc.acc = w_s1.v;
                end
                2, 3: begin
                    w_nc.pw  = w_ra;
                    w_nc.ph  = w_dc.pw;
                    w_s1     = sadd(w_dc.acc, w_rb);
                    w_nc.acc = w_s1.v;
                end
                4: begin
                    w_s1     = sadd(w_dc.acc, w_ra);
                    w_s2     = sadd(w_s1.v, w_rb);
                    w_nc.acc = w_s2.v;
                end
                default: ;
            endcase
            w_nc.clip = w_dc.clip | w_ca | w_cb | w_s1.c | w_s2.c;
        end

        assign w_ctx[k+1] = w_nc;
        assign w_vld[k+1] = w_va;
    end

    // clamp to the output width
    always_comb begin
        n_position  = w_ctx[EVAL_STEPS].acc[DATA_WIDTH-1:0];
        n_saturated = w_ctx[EVAL_STEPS].clip;
        if (!w_ctx[EVAL_STEPS].acc[ACC_W-1] && (|w_ctx[EVAL_STEPS].acc[ACC_W-2:DATA_WIDTH-1])) begin
            n_position  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            n_saturated = 1'b1;
        end else if (w_ctx[EVAL_STEPS].acc[ACC_W-1]
                     && !(&w_ctx[EVAL_STEPS].acc[ACC_W-2:DATA_WIDTH-1])) begin
            n_position  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            n_saturated = 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_vld[EVAL_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_vld[EVAL_STEPS]) begin
            r_position  <= n_position;
            r_saturated <= n_saturated;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_position  = r_position;
    assign o_saturated = r_saturated;

`ifndef NO_ASSERTIONS
    // a register write closes the input until the new solve ends
    a_write_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> !o_ready)
        else $error("input open right after a register write");

    // a held output freezes the pipeline tail
    a_tail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_vld[EVAL_STEPS]))
        else $error("pipeline moved during a stall");

    // a waiting result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_position) && $stable(o_saturated)))
        else $error("result changed while waiting");
`endif

endmodule
`default_nettype wire

### tb/quintic_min_jerk_trajectory_tb.sv
// self-checking testbench of the quintic min-jerk trajectory block
`timescale 1ns / 100ps
`default_nettype none
module quintic_min_jerk_trajectory_tb;
    import qmj_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(7);
    localparam int SETTLE = 60;
    localparam int RANDOM_ITEMS = 900;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] pos;
        logic                         sat;
    } t_point;

    typedef struct {
        bit                    is_cfg;
        logic [IDX_W-1:0]      idx;
        logic [DATA_WIDTH-1:0] data;
        logic [TIME_W-1:0]     t;
        bit                    typed;
        t_point                want;
    } t_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [IDX_W-1:0]             i_cfg_index = '0;
    logic [DATA_WIDTH-1:0]        i_cfg_data = '0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [TIME_W-1:0]            i_sample_time = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic signed [DATA_WIDTH-1:0] o_position;
    logic                         o_saturated;

    quintic_min_jerk_trajectory u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_sample_time(i_sample_time),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_position(o_position), .o_saturated(o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // trajectory predictor state
    logic [DATA_WIDTH-1:0]   shadow_regs [NREG];
    logic signed [ACC_W-1:0] coef [6];
    bit                      coef_ok;
    bit                      coef_ovf;
    bit                      ovf;

    t_point positions_due [$];
    int     mismatches = 0;

    // floor(a*b / 2^sh) saturated to 64 bits
    function automatic logic signed [ACC_W-1:0] mul_shift(input logic signed [ACC_W-1:0] a,
                                                         input logic signed [ACC_W-1:0] b,
                                                         input int sh);
        logic signed [127:0] p;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        p = p >>> sh;
        if (p[127:63] != {65{p[127]}}) begin
            ovf = 1'b1;
            return p[127] ? SMIN : SMAX;
        end
        return p[63:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] add_sat(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            ovf = 1'b1;
            return a[63] ? SMIN : SMAX;
        end
        return s;
    endfunction

    function automatic logic signed [ACC_W-1:0] duration_eff();
        logic [DUR_W-1:0] d;
        d = shadow_regs[REG_DURATION][DUR_W-1:0];
        return (d == '0) ? 64'sd1 : $signed({33'd0, d});
    endfunction

    function automatic logic signed [ACC_W-1:0] reg_val(input logic [IDX_W-1:0] i);
        return $signed({{32{shadow_regs[i][31]}}, shadow_regs[i]});
    endfunction

    // closed-form quintic coefficient solve
    function automatic void solve_coefs();
        logic signed [ACC_W-1:0] s0, v0, a0, s1, v1, a1, dt, dt2, reach, b0, b1, b2;
        logic signed [ACC_W-1:0] tb1, t2b2, half;
        s0 = reg_val(REG_START_POS); v0 = reg_val(REG_START_VEL);
        a0 = reg_val(REG_START_ACC); s1 = reg_val(REG_END_POS);
        v1 = reg_val(REG_END_VEL);   a1 = reg_val(REG_END_ACC);
        dt = duration_eff();
        ovf = 1'b0;
        dt2 = mul_shift(dt, dt, FRAC_BITS);
        reach = add_sat(add_sat(s0, mul_shift(v0, dt, FRAC_BITS)),
                        mul_shift(a0, dt2, FRAC_BITS + 1));
        b0 = add_sat(s1, (reach == SMIN) ? SMAX : -reach);
        b1 = add_sat(v1, mul_shift(add_sat(v0, mul_shift(a0, dt, FRAC_BITS)), -64'sd1, 0));
        b2 = a1 - a0;
        tb1 = mul_shift(dt, b1, FRAC_BITS);
        t2b2 = mul_shift(dt2, b2, FRAC_BITS);
        half = mul_shift(dt2, b2, FRAC_BITS + 1);
        coef[0] = s0;
        coef[1] = v0;
        coef[2] = a0;
        coef[3] = add_sat(add_sat(mul_shift(b0, 64'sd10, 0), mul_shift(tb1, -64'sd4, 0)), half);
        coef[4] = add_sat(add_sat(mul_shift(b0, -64'sd15, 0), mul_shift(tb1, 64'sd7, 0)),
                          mul_shift(t2b2, -64'sd1, 0));
        coef[5] = add_sat(add_sat(mul_shift(b0, 64'sd6, 0), mul_shift(tb1, -64'sd3, 0)), half);
        coef_ovf = ovf;
        coef_ok = 1'b1;
    endfunction

    // position at one sample time
    function automatic t_point eval_position(input logic [TIME_W-1:0] t);
        t_point                  r;
        logic [63:0]             q;
        logic signed [ACC_W-1:0] ts, tau, p2, p3, p4, p5, s;
        if (!coef_ok) solve_coefs();
        ovf = coef_ovf;
        ts = $signed({33'd0, t});
        q = {1'b0, t, 32'd0} / duration_eff();
        tau = q;
        p2 = mul_shift(tau, tau, TAU_BITS);
        p3 = mul_shift(p2, tau, TAU_BITS);
        p4 = mul_shift(p3, tau, TAU_BITS);
        p5 = mul_shift(p4, tau, TAU_BITS);
        s = add_sat(coef[0], mul_shift(coef[1], ts, FRAC_BITS));
        s = add_sat(s, mul_shift(coef[2], mul_shift(ts, ts, FRAC_BITS), FRAC_BITS + 1));
        s = add_sat(s, mul_shift(coef[3], p3, TAU_BITS));
        s = add_sat(s, mul_shift(coef[4], p4, TAU_BITS));
        s = add_sat(s, mul_shift(coef[5], p5, TAU_BITS));
        if (s > 64'sh7fffffff) begin s = 64'sh7fffffff; ovf = 1'b1; end
        if (s < -64'sh80000000) begin s = -64'sh80000000; ovf = 1'b1; end
        r.pos = s[DATA_WIDTH-1:0];
        r.sat = ovf;
        return r;
    endfunction

    // result checker and receiver stall pattern
    int unsigned stall_cnt = 0;
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_valid && i_ready) begin
            if (positions_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result pos=%0d sat=%0b",
                                               o_position, o_saturated);
            end else begin
                want = positions_due.pop_front();
                if (want.pos !== o_position || want.sat !== o_saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected pos=%0d sat=%0b, got pos=%0d sat=%0b",
                                 want.pos, want.sat, o_position, o_saturated);
                end
            end
        end
        stall_cnt++;
        case ((stall_cnt / 97) % 4)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= ($urandom_range(0, 7) == 0);
            default: i_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic wait_idle();
        while (positions_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write, only while idle; the next sample transaction drops the enable
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_WIDTH-1:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        if (idx < NREG) begin
            shadow_regs[idx] = d;
            coef_ok = 1'b0;
        end
    endtask

    // one sample transaction, followed in one case of six by a random gap
    task automatic send_sample(input logic [TIME_W-1:0] t, input bit typed, input t_point want);
        t_point p;
        i_cfg_we <= 1'b0;
        i_valid <= 1'b1;
        i_sample_time <= t;
        do @(posedge i_clk); while (!o_ready);
        p = eval_position(t);
        if (typed && (p.pos !== want.pos || p.sat !== want.sat)) begin
            mismatches++;
            if (mismatches <= 10) $display("table entry disagrees with predictor at t=%0d", t);
        end
        if (!typed) want = p;
        positions_due.insert(positions_due.size(), want);
        if ($urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    function automatic logic [DATA_WIDTH-1:0] rand_state();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            3: return 32'd0;
            default: return DATA_WIDTH'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_duration();
        case ($urandom_range(0, 11))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'h7fffffff;
            3: return $urandom();
            default: return $urandom_range(4096, 4 * 65536);
        endcase
    endfunction

    t_row   stim [$];
    t_point none = '{pos: '0, sat: 1'b0};

    function automatic void cfg_row(input logic [IDX_W-1:0] idx, input logic [DATA_WIDTH-1:0] d);
        t_row r;
        r = '{is_cfg: 1'b1, idx: idx, data: d, t: '0, typed: 1'b0, want: none};
        stim.insert(stim.size(), r);
    endfunction

    function automatic void item_row(input logic [TIME_W-1:0] t, input bit typed,
                                     input logic signed [DATA_WIDTH-1:0] pos, input logic sat);
        t_row r;
        r = '{is_cfg: 1'b0, idx: '0, data: '0, t: t, typed: typed,
              want: '{pos: pos, sat: sat}};
        stim.insert(stim.size(), r);
    endfunction

    initial begin
        logic [TIME_W-1:0] t, dur_now;
        bit                was_item;
        int                sent;
        for (int i = 0; i < NREG; i++) shadow_regs[i] = '0;
        shadow_regs[REG_DURATION] = 32'(DUR_RESET);
        coef_ok = 1'b0;

        // directed table: reset config gives a flat zero trajectory
        item_row(31'd0, 1'b1, '0, 1'b0);
        item_row(31'd65536, 1'b1, '0, 1'b0);
        item_row(31'h7fffffff, 1'b1, '0, 1'b1);
        // every register at its top value, shortest duration
        for (int i = 0; i < NREG - 1; i++) cfg_row(IDX_W'(i), 32'h7fffffff);
        cfg_row(REG_DURATION, 32'd1);
        item_row(31'd0, 1'b0, '0, 1'b0);
        item_row(31'd1, 1'b0, '0, 1'b0);
        item_row(31'h7fffffff, 1'b0, '0, 1'b0);
        // bottom values, zero duration counts as one lsb
        for (int i = 0; i < NREG - 1; i++) cfg_row(IDX_W'(i), 32'h80000000);
        cfg_row(REG_DURATION, 32'd0);
        item_row(31'd0, 1'b0, '0, 1'b0);
        item_row(31'd1, 1'b0, '0, 1'b0);
        item_row(31'h7fffffff, 1'b0, '0, 1'b0);
        // rest to rest move over 2 s, then past its end
        for (int i = 0; i < NREG - 1; i++) cfg_row(IDX_W'(i), '0);
        cfg_row(REG_END_POS, 32'd655360);
        cfg_row(REG_DURATION, 32'h7fffffff);
        cfg_row(REG_DURATION, 32'd131072);
        cfg_row(REG_UNUSED, 32'hdeadbeef);
        item_row(31'd0, 1'b1, '0, 1'b0);
        item_row(31'd65536, 1'b0, '0, 1'b0);
        item_row(31'd131072, 1'b0, '0, 1'b0);
        item_row(31'd262144, 1'b0, '0, 1'b0);
        item_row(31'd3276800, 1'b0, '0, 1'b0);
        // velocity and acceleration at both ends
        cfg_row(REG_START_VEL, 32'hfffe0000);
        cfg_row(REG_START_ACC, 32'd98304);
        cfg_row(REG_END_VEL, 32'd65536);
        cfg_row(REG_END_ACC, 32'hffff0000);
        item_row(31'd32768, 1'b0, '0, 1'b0);
        item_row(31'd100000, 1'b0, '0, 1'b0);
        item_row(31'd131071, 1'b0, '0, 1'b0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        was_item = 1'b0;
        foreach (stim[k]) begin
            if (stim[k].is_cfg) begin
                if (was_item) begin
                    i_valid <= 1'b0;
                    wait_idle();
                end
                write_reg(stim[k].idx, stim[k].data);
                was_item = 1'b0;
            end else begin
                send_sample(stim[k].t, stim[k].typed, stim[k].want);
                was_item = 1'b1;
            end
        end

        // random phases of fresh trajectories
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            i_valid <= 1'b0;
            wait_idle();
            for (int i = 0; i < NREG - 1; i++)
                if ($urandom_range(0, 3) != 0) write_reg(IDX_W'(i), rand_state());
            if ($urandom_range(0, 3) != 0) write_reg(REG_DURATION, rand_duration());
            if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom());
            dur_now = shadow_regs[REG_DURATION][DUR_W-1:0];
            for (int n = $urandom_range(20, 120); n > 0 && sent < RANDOM_ITEMS; n--) begin
                if ($urandom_range(0, 4) == 0 || dur_now > 31'h60000000)
                    t = TIME_W'($urandom());
                else
                    t = TIME_W'($urandom_range(0, dur_now + dur_now / 4));
                send_sample(t, 1'b0, none);
                sent++;
                // hold off until the pipeline has drained
                if (sent == RANDOM_ITEMS / 2) begin
                    i_valid <= 1'b0;
                    while (positions_due.size() != 0) @(posedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;

        while (positions_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
src/qmj_pkg.sv
src/qmj_mul.sv
src/qmj_div.sv
src/qmj_solve.sv
src/quintic_min_jerk_trajectory.sv
tb/quintic_min_jerk_trajectory_tb.sv
